// File: sv/isf_pkg.sv
`timescale 1ns / 1ps
package isf_pkg;

   localparam int MAX_SETS_DEF     = 256;
   localparam int MAX_SET_SIZE_DEF = 16;
   localparam int MAX_TRACE_DEF    = 64;

   localparam int VAL_W = 16;
   localparam int OP_W  = 2;
   localparam int ERR_W = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH = 2'd1;
   localparam logic [OP_W-1:0] OP_POP  = 2'd2;
   localparam logic [OP_W-1:0] OP_RST  = 2'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
   localparam logic [ERR_W-1:0] ERR_STORE_FULL = 3'd1;
   localparam logic [ERR_W-1:0] ERR_SET_LONG   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_TRACE_FULL = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TRACE_EMPTY = 3'd4;

   typedef logic signed [VAL_W-1:0] value_type;

endpackage

// File: sv/incremental_superset_finder.sv
`timescale 1ns / 1ps
// incremental superset finder
// request channel: req_tdata carries the element value, req_tuser carries the
// operation (add, push, pop, reset trace) and the element present flag, and
// req_tlast closes the set being loaded on an add transaction
// response channel: exactly one transaction per request, carrying the found
// flag, the superset pointer, the popped value and an error code
// the block works on one request at a time; req_tready is high only while
// the sequencer is idle
// work per request: add shifts larger elements up for a sorted insert; pop
// removes the popped value from the sorted trace and closes the gap; push
// does a sorted insert into the trace, then a merge walk of each stored set
// walked by the containment test (a step reads one set element and one sorted
// trace element from the two memories)
// reset empties the set store, the loading set and the trace, pointer to 0;
// the memories need no clearing pass since no entry is read before written
// a stalled response stays in the output register; one more request may be
// accepted meanwhile and its result waits in the sequencer until the
// register frees
module incremental_superset_finder #(
   parameter int MAX_SETS     = isf_pkg::MAX_SETS_DEF,
   parameter int MAX_SET_SIZE = isf_pkg::MAX_SET_SIZE_DEF,
   parameter int MAX_TRACE    = isf_pkg::MAX_TRACE_DEF,
   localparam int CW = $clog2(MAX_SETS + 1),
   localparam int RW = ((isf_pkg::ERR_W + isf_pkg::VAL_W + CW + 1 + 7) / 8) * 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,  // element_value
   input  logic [2:0]    req_tuser,  // operation, element_present
   input  logic          req_tlast,  // last_of_set
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [RW-1:0] rsp_tdata   // superset_found, superset_index, popped_value, error_code
);

   localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int PW = (MAX_SET_SIZE > 1) ? $clog2(MAX_SET_SIZE) : 1;
   localparam int TW = (MAX_TRACE > 1) ? $clog2(MAX_TRACE) : 1;
   localparam int LW = $clog2(MAX_SET_SIZE + 1);
   localparam int DW = $clog2(MAX_TRACE + 1);
   localparam int PAD = RW - (isf_pkg::ERR_W + isf_pkg::VAL_W + CW + 1);

   // sequencer states
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_INS   = 5'd1;   // insertion into loading set
   localparam logic [4:0] S_INSW  = 5'd2;
   localparam logic [4:0] S_CLOSE = 5'd3;
   localparam logic [4:0] S_TINS  = 5'd4;   // insertion into sorted trace
   localparam logic [4:0] S_TINSW = 5'd5;
   localparam logic [4:0] S_SCAN  = 5'd6;   // start test of set under pointer
   localparam logic [4:0] S_LENW  = 5'd7;
   localparam logic [4:0] S_STEP  = 5'd8;   // merge walk
   localparam logic [4:0] S_STEPW = 5'd9;
   localparam logic [4:0] S_POPW  = 5'd10;
   localparam logic [4:0] S_RM    = 5'd11;  // find popped value in sorted trace
   localparam logic [4:0] S_RMW   = 5'd12;
   localparam logic [4:0] S_SH    = 5'd13;  // close the gap
   localparam logic [4:0] S_SHW   = 5'd14;
   localparam logic [4:0] S_FIN   = 5'd15;

   // storage
   isf_pkg::value_type elem_mem [0:(2**(SW+PW))-1];
   logic [LW-1:0]      len_mem  [0:(2**SW)-1];
   isf_pkg::value_type trc_mem  [0:(2**TW)-1];
   logic [CW-1:0]      sav_mem  [0:(2**TW)-1];
   isf_pkg::value_type srt_mem  [0:(2**TW)-1];

   logic [4:0] state_ff, state_in;
   isf_pkg::value_type val_ff, val_in;
   logic last_ff, last_in;
   logic close_ff, close_in;
   logic [isf_pkg::ERR_W-1:0] err_ff, err_in;
   logic found_ff, found_in;
   isf_pkg::value_type popped_ff, popped_in;
   logic [CW-1:0] cnt_ff, cnt_in, ptr_ff, ptr_in, tset_ff, tset_in;
   logic [LW-1:0] load_ff, load_in, sj_ff, sj_in, a_ff, a_in, tlen_ff, tlen_in;
   logic [DW-1:0] depth_ff, depth_in, tj_ff, tj_in, t_ff, t_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic elem_we, len_we, trc_we, srt_we;
   logic [SW+PW-1:0] elem_wa, elem_ra;
   logic [SW-1:0] len_wa, len_ra;
   logic [TW-1:0] trc_wa, trc_ra, srt_wa, srt_ra;
   isf_pkg::value_type elem_wd, trc_wd, srt_wd;
   isf_pkg::value_type elem_rd_ff, trc_rd_ff, srt_rd_ff;
   logic [LW-1:0] len_wd, len_rd_ff;
   logic [CW-1:0] sav_wd, sav_rd_ff;

   logic [isf_pkg::OP_W-1:0] req_op;
   logic req_pres, miss;

   assign req_op     = req_tuser[1:0];
   assign req_pres   = req_tuser[2];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (elem_we) elem_mem[elem_wa] <= elem_wd;
      if (len_we)  len_mem[len_wa]   <= len_wd;
      if (trc_we) begin
         trc_mem[trc_wa] <= trc_wd;
         sav_mem[trc_wa] <= sav_wd;
      end
      if (srt_we)  srt_mem[srt_wa]   <= srt_wd;
      elem_rd_ff <= elem_mem[elem_ra];
      len_rd_ff  <= len_mem[len_ra];
      trc_rd_ff  <= trc_mem[trc_ra];
      sav_rd_ff  <= sav_mem[trc_ra];
      srt_rd_ff  <= srt_mem[srt_ra];
   end

   always_comb begin
      state_in = state_ff; val_in = val_ff; last_in = last_ff;
      close_in = close_ff; err_in = err_ff; found_in = found_ff;
      popped_in = popped_ff; cnt_in = cnt_ff; ptr_in = ptr_ff; tset_in = tset_ff;
      load_in = load_ff; sj_in = sj_ff; a_in = a_ff; tlen_in = tlen_ff;
      depth_in = depth_ff; tj_in = tj_ff; t_in = t_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      elem_we = 1'b0; elem_wa = '0; elem_wd = val_ff; elem_ra = '0;
      len_we = 1'b0; len_wa = '0; len_wd = load_ff; len_ra = '0;
      trc_we = 1'b0; trc_wa = '0; trc_wd = val_ff; sav_wd = ptr_ff; trc_ra = '0;
      srt_we = 1'b0; srt_wa = '0; srt_wd = val_ff; srt_ra = '0;
      miss = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               val_in = req_tdata;
               last_in = req_tlast;
               close_in = 1'b0;
               found_in = 1'b0;
               popped_in = '0;
               err_in = isf_pkg::ERR_OK;
               state_in = S_FIN;
               case (req_op)
                  isf_pkg::OP_ADD: begin
                     if (cnt_ff == CW'(MAX_SETS)) begin
                        err_in = isf_pkg::ERR_STORE_FULL;
                     end else if (req_pres && load_ff == LW'(MAX_SET_SIZE)) begin
                        err_in = isf_pkg::ERR_SET_LONG;
                     end else if (req_pres) begin
                        sj_in = load_ff;
                        state_in = S_INS;
                     end else if (req_tlast) begin
                        state_in = S_CLOSE;
                     end
                  end
                  isf_pkg::OP_PUSH: begin
                     if (depth_ff == DW'(MAX_TRACE)) begin
                        err_in = isf_pkg::ERR_TRACE_FULL;
                     end else begin
                        trc_we = 1'b1;
                        trc_wa = depth_ff[TW-1:0];
                        trc_wd = req_tdata;
                        tj_in = depth_ff;
                        state_in = S_TINS;
                     end
                  end
                  isf_pkg::OP_POP: begin
                     if (depth_ff == '0) begin
                        err_in = isf_pkg::ERR_TRACE_EMPTY;
                     end else begin
                        depth_in = depth_ff - DW'(1);
                        trc_ra = depth_in[TW-1:0];
                        state_in = S_POPW;
                     end
                  end
                  default: begin
                     depth_in = '0;
                     ptr_in = '0;
                  end
               endcase
            end
         end
         S_INS: begin
            if (sj_ff == '0) begin
               elem_we = 1'b1;
               elem_wa = {cnt_ff[SW-1:0], PW'(0)};
               load_in = load_ff + LW'(1);
               state_in = last_ff ? S_CLOSE : S_FIN;
            end else begin
               elem_ra = {cnt_ff[SW-1:0], PW'(sj_ff - LW'(1))};
               state_in = S_INSW;
            end
         end
         S_INSW: begin
            elem_we = 1'b1;
            elem_wa = {cnt_ff[SW-1:0], PW'(sj_ff)};
            if (elem_rd_ff > val_ff) begin
               elem_wd = elem_rd_ff;
               sj_in = sj_ff - LW'(1);
               state_in = S_INS;
            end else begin
               load_in = load_ff + LW'(1);
               state_in = last_ff ? S_CLOSE : S_FIN;
            end
         end
         S_CLOSE: begin
            len_we = 1'b1;
            len_wa = cnt_ff[SW-1:0];
            load_in = '0;
            cnt_in = cnt_ff + CW'(1);
            state_in = S_FIN;
            if (ptr_ff == cnt_ff) begin
               tset_in = cnt_ff;
               tlen_in = load_ff;
               a_in = '0;
               t_in = '0;
               close_in = 1'b1;
               state_in = S_STEP;
            end
         end
         S_TINS: begin
            if (tj_ff == '0) begin
               srt_we = 1'b1;
               srt_wa = '0;
               depth_in = depth_ff + DW'(1);
               state_in = S_SCAN;
            end else begin
               srt_ra = TW'(tj_ff - DW'(1));
               state_in = S_TINSW;
            end
         end
         S_TINSW: begin
            srt_we = 1'b1;
            srt_wa = tj_ff[TW-1:0];
            if (srt_rd_ff > val_ff) begin
               srt_wd = srt_rd_ff;
               tj_in = tj_ff - DW'(1);
               state_in = S_TINS;
            end else begin
               depth_in = depth_ff + DW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ptr_ff < cnt_ff) begin
               tset_in = ptr_ff;
               len_ra = ptr_ff[SW-1:0];
               state_in = S_LENW;
            end else begin
               found_in = 1'b0;
               state_in = S_FIN;
            end
         end
         S_LENW: begin
            tlen_in = len_rd_ff;
            a_in = '0;
            t_in = '0;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (t_ff == depth_ff) begin
               found_in = ~close_ff;
               state_in = S_FIN;
            end else if (a_ff == tlen_ff) begin
               miss = 1'b1;
            end else begin
               srt_ra = t_ff[TW-1:0];
               elem_ra = {tset_ff[SW-1:0], a_ff[PW-1:0]};
               state_in = S_STEPW;
            end
         end
         S_STEPW: begin
            state_in = S_STEP;
            if (elem_rd_ff < srt_rd_ff) begin
               a_in = a_ff + LW'(1);
            end else if (elem_rd_ff == srt_rd_ff) begin
               a_in = a_ff + LW'(1);
               t_in = t_ff + DW'(1);
            end else begin
               miss = 1'b1;
            end
         end
         S_POPW: begin
            popped_in = trc_rd_ff;
            ptr_in = sav_rd_ff;
            tj_in = '0;
            state_in = S_RM;
         end
         S_RM: begin
            srt_ra = tj_ff[TW-1:0];
            state_in = S_RMW;
         end
         S_RMW: begin
            if (srt_rd_ff == popped_ff) begin
               state_in = S_SH;
            end else begin
               tj_in = tj_ff + DW'(1);
               state_in = S_RM;
            end
         end
         S_SH: begin
            if (tj_ff >= depth_ff) begin
               state_in = S_FIN;
            end else begin
               srt_ra = TW'(tj_ff + DW'(1));
               state_in = S_SHW;
            end
         end
         S_SHW: begin
            srt_we = 1'b1;
            srt_wa = tj_ff[TW-1:0];
            srt_wd = srt_rd_ff;
            tj_in = tj_ff + DW'(1);
            state_in = S_SH;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {PAD'(0), err_ff, popped_ff, ptr_ff, found_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // containment test failed on the set under test
      if (miss) begin
         if (close_ff) begin
            ptr_in = cnt_ff;
            state_in = S_FIN;
         end else begin
            ptr_in = ptr_ff + CW'(1);
            state_in = S_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         load_ff <= '0;
         depth_ff <= '0;
         ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         load_ff <= load_in;
         depth_ff <= depth_in;
         ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff <= val_in;
      last_ff <= last_in;
      close_ff <= close_in;
      err_ff <= err_in;
      found_ff <= found_in;
      popped_ff <= popped_in;
      tset_ff <= tset_in;
      sj_ff <= sj_in;
      a_ff <= a_in;
      tlen_ff <= tlen_in;
      tj_ff <= tj_in;
      t_ff <= t_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sv/isf_checker.sv
`timescale 1ns / 1ps
module isf_checker #(
   parameter int RW = 32,
   parameter int CW = 9
) (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [RW-1:0] rsp_tdata
);

   localparam int ERR_LO = CW + 1 + isf_pkg::VAL_W;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // found only without error
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[ERR_LO+2:ERR_LO] == isf_pkg::ERR_OK)
      else $error("found flag with error");

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response after reset");

endmodule

bind incremental_superset_finder isf_checker #(.RW(RW), .CW(CW)) u_isf_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: bench/incremental_superset_finder_tb.sv
`timescale 1ns / 1ps
module incremental_superset_finder_tb;

   localparam int N_SETS  = isf_pkg::MAX_SETS_DEF;
   localparam int SET_MAX = isf_pkg::MAX_SET_SIZE_DEF;
   localparam int TR_MAX  = isf_pkg::MAX_TRACE_DEF;

   // one response transaction, fields as packed on rsp_tdata, listed from the highest bit down
   typedef struct packed {
      logic [isf_pkg::ERR_W-1:0] err;
      isf_pkg::value_type        popped;
      logic [8:0]                index;
      logic                      found;
   } rsp_fields_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // element_value
   logic [2:0]  req_tuser = '0;   // operation, element_present
   logic        req_tlast = 1'b0; // last_of_set
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // superset_found, superset_index, popped_value, error_code

   incremental_superset_finder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // shadow copy of the set store and trace stack
   isf_pkg::value_type set_vals [N_SETS][SET_MAX];
   int                 set_len [N_SETS];
   int                 sets_stored;
   int                 loading_len;
   isf_pkg::value_type trace_vals [TR_MAX];
   int                 trace_ptr_saved [TR_MAX];
   int                 trace_depth;
   int                 superset_ptr;

   rsp_fields_type pending_results[$];
   int             error_count = 0;
   int             responses_seen = 0;
   int             burst_left = 0;

   // multiset containment of the current trace in stored set s
   function automatic bit set_holds_trace(int s);
      isf_pkg::value_type sorted [TR_MAX];
      isf_pkg::value_type v;
      int                 j;
      int                 a;
      a = 0;
      for (int i = 0; i < trace_depth; i++) begin
         v = trace_vals[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      for (int t = 0; t < trace_depth; t++) begin
         while (a < set_len[s] && set_vals[s][a] < sorted[t]) a++;
         if (a >= set_len[s] || set_vals[s][a] != sorted[t]) return 1'b0;
         a++;
      end
      return 1'b1;
   endfunction

   // advance the shadow state by one request and return its response
   function automatic rsp_fields_type compute_response(logic [isf_pkg::OP_W-1:0] op,
                                                       isf_pkg::value_type val,
                                                       bit present, bit last);
      rsp_fields_type r;
      int             j;
      r = '0;
      case (op)
         isf_pkg::OP_ADD: begin
            if (sets_stored >= N_SETS) begin
               r.err = isf_pkg::ERR_STORE_FULL;
            end else if (present && loading_len >= SET_MAX) begin
               r.err = isf_pkg::ERR_SET_LONG;
            end else begin
               if (present) begin
                  // sorted insert into the set being loaded
                  j = loading_len;
                  while (j > 0 && set_vals[sets_stored][j-1] > val) begin
                     set_vals[sets_stored][j] = set_vals[sets_stored][j-1];
                     j--;
                  end
                  set_vals[sets_stored][j] = val;
                  loading_len++;
               end
               if (last) begin
                  set_len[sets_stored] = loading_len;
                  loading_len = 0;
                  sets_stored++;
                  // pointer parked at the end: test the new set
                  if (superset_ptr == sets_stored - 1 && !set_holds_trace(sets_stored - 1))
                     superset_ptr = sets_stored;
               end
            end
         end
         isf_pkg::OP_PUSH: begin
            if (trace_depth >= TR_MAX) begin
               r.err = isf_pkg::ERR_TRACE_FULL;
            end else begin
               trace_vals[trace_depth] = val;
               trace_ptr_saved[trace_depth] = superset_ptr;
               trace_depth++;
               while (superset_ptr < sets_stored && !set_holds_trace(superset_ptr))
                  superset_ptr++;
               r.found = superset_ptr < sets_stored;
            end
         end
         isf_pkg::OP_POP: begin
            if (trace_depth == 0) begin
               r.err = isf_pkg::ERR_TRACE_EMPTY;
            end else begin
               trace_depth--;
               superset_ptr = trace_ptr_saved[trace_depth];
               r.popped = trace_vals[trace_depth];
            end
         end
         default: begin
            trace_depth = 0;
            superset_ptr = 0;
         end
      endcase
      r.index = superset_ptr[8:0];
      return r;
   endfunction

   // offer one request, wait for the transaction, then maybe leave a gap
   task automatic send_request(logic [isf_pkg::OP_W-1:0] op, isf_pkg::value_type val,
                               bit present, bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= {present, op};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(),
                             compute_response(op, val, present, last));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic isf_pkg::value_type pick_value();
      // small range so sets and traces overlap, full range now and then
      if ($urandom_range(0, 9) < 8)
         return isf_pkg::value_type'($signed($urandom_range(0, 8)) - 4);
      return isf_pkg::value_type'($urandom);
   endfunction

   // load a whole set through add transactions
   task automatic load_set(int n);
      for (int i = 0; i < n; i++)
         send_request(isf_pkg::OP_ADD, pick_value(), 1'b1, i == n - 1);
      if (n == 0) send_request(isf_pkg::OP_ADD, '0, 1'b0, 1'b1);
   endtask

   task automatic test_basic_sets();
      send_request(isf_pkg::OP_POP, '0, 1'b0, 1'b0);          // pop on empty trace
      send_request(isf_pkg::OP_PUSH, 16'sd3, 1'b0, 1'b0);      // push with no sets stored
      send_request(isf_pkg::OP_ADD, '0, 1'b0, 1'b1);           // empty set
      send_request(isf_pkg::OP_ADD, 16'sd3, 1'b1, 1'b0);
      send_request(isf_pkg::OP_ADD, 16'sd1, 1'b1, 1'b0);
      send_request(isf_pkg::OP_ADD, 16'sd3, 1'b0, 1'b0);       // neither element nor close
      send_request(isf_pkg::OP_ADD, 16'sd3, 1'b1, 1'b1);       // duplicate closes {1,3,3}
      send_request(isf_pkg::OP_PUSH, 16'sd3, 1'b0, 1'b1);
      send_request(isf_pkg::OP_PUSH, 16'sd3, 1'b1, 1'b0);
      send_request(isf_pkg::OP_PUSH, 16'sd3, 1'b0, 1'b0);      // pointer already past the stored sets
      send_request(isf_pkg::OP_ADD, 16'sd3, 1'b1, 1'b0);       // new set tested at pointer end
      send_request(isf_pkg::OP_ADD, 16'sd3, 1'b1, 1'b0);
      send_request(isf_pkg::OP_ADD, 16'sd3, 1'b1, 1'b1);
      send_request(isf_pkg::OP_POP, '0, 1'b0, 1'b0);
      send_request(isf_pkg::OP_RST, 16'sd7, 1'b1, 1'b1);
   endtask

   task automatic test_extremes();
      send_request(isf_pkg::OP_ADD, 16'sh7fff, 1'b1, 1'b0);
      send_request(isf_pkg::OP_ADD, -16'sh8000, 1'b1, 1'b0);
      send_request(isf_pkg::OP_ADD, 16'sh0000, 1'b1, 1'b1);
      send_request(isf_pkg::OP_PUSH, -16'sh8000, 1'b0, 1'b0);
      send_request(isf_pkg::OP_PUSH, 16'sh7fff, 1'b0, 1'b0);
      send_request(isf_pkg::OP_POP, 16'shffff, 1'b1, 1'b1);
      send_request(isf_pkg::OP_POP, '0, 1'b0, 1'b0);
      send_request(isf_pkg::OP_RST, '0, 1'b0, 1'b0);
   endtask

   task automatic test_set_too_long();
      for (int i = 0; i < SET_MAX; i++)
         send_request(isf_pkg::OP_ADD, pick_value(), 1'b1, 1'b0);
      send_request(isf_pkg::OP_ADD, 16'sd5, 1'b1, 1'b0);        // one element too many
      send_request(isf_pkg::OP_ADD, 16'sd5, 1'b1, 1'b1);        // rejected whole, no close
      send_request(isf_pkg::OP_ADD, '0, 1'b0, 1'b1);
   endtask

   task automatic test_trace_limits();
      for (int i = 0; i <= TR_MAX; i++)
         send_request(isf_pkg::OP_PUSH, pick_value(), 1'b0, 1'b0);
      for (int i = 0; i <= TR_MAX; i++)
         send_request(isf_pkg::OP_POP, '0, 1'b0, 1'b0);
   endtask

   task automatic test_random(int n_items);
      int sent;
      int pick;
      int n;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 35 && sets_stored < 200) begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            load_set(n);
            sent += (n == 0) ? 1 : n;
         end else if (pick < 75) begin
            send_request(isf_pkg::OP_PUSH, pick_value(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 90) begin
            send_request(isf_pkg::OP_POP, pick_value(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 95) begin
            send_request(isf_pkg::OP_RST, pick_value(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            sent++;
         end else begin
            // noise: stray element without close, or a bare add
            send_request(isf_pkg::OP_ADD, pick_value(), 1'($urandom_range(0, 1)), 1'b0);
            sent++;
         end
      end
   endtask

   task automatic test_store_full();
      if (loading_len > 0) send_request(isf_pkg::OP_ADD, '0, 1'b0, 1'b1);
      send_request(isf_pkg::OP_RST, '0, 1'b0, 1'b0);
      send_request(isf_pkg::OP_PUSH, 16'sd2, 1'b0, 1'b0);
      while (sets_stored < N_SETS) send_request(isf_pkg::OP_ADD, '0, 1'b0, 1'b1);
      send_request(isf_pkg::OP_ADD, 16'sd1, 1'b1, 1'b1);        // store full
      send_request(isf_pkg::OP_POP, '0, 1'b0, 1'b0);
      send_request(isf_pkg::OP_PUSH, 16'sd9, 1'b0, 1'b0);       // scan over the full store
   endtask

   // response side: stall patterns that change from stretch to stretch, plus one long hold
   initial begin
      int mode;
      int stretch;
      int hold;
      bit held;
      mode = 0;
      stretch = 0;
      hold = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && responses_seen >= 40) begin
            held = 1'b1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (stretch == 0) begin
               mode = $urandom_range(0, 2);
               stretch = $urandom_range(10, 80);
            end
            stretch--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // compare every response transaction with the oldest expectation
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[28:0];
         responses_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response found=%0d index=%0d popped=%0d err=%0d",
                     $time, got.found, got.index, got.popped, got.err);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected found=%0d index=%0d popped=%0d err=%0d",
                        $time, want.found, want.index, want.popped, want.err);
               $display("%0t:          actual   found=%0d index=%0d popped=%0d err=%0d",
                        $time, got.found, got.index, got.popped, got.err);
               error_count++;
            end
         end
      end
   end

   initial begin
      #1s;
      $display("incremental_superset_finder_tb: errors");
      $finish;
   end

   initial begin
      sets_stored = 0;
      loading_len = 0;
      trace_depth = 0;
      superset_ptr = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_sets();
      test_extremes();
      test_set_too_long();
      test_trace_limits();
      test_random(300);
      test_store_full();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("incremental_superset_finder_tb: clean");
      else
         $display("incremental_superset_finder_tb: errors");
      $finish;
   end

endmodule

// File: filelist.f
sv/isf_pkg.sv
sv/incremental_superset_finder.sv
sv/isf_checker.sv
bench/incremental_superset_finder_tb.sv
